/* hw/rtl/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// Types, constants and spectral mask tables shared by the interference
// spreader modules.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int TAB_LEN   = 8;
  localparam int TAB_IDX_W = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_CHANNEL = 4'd1;

  localparam logic signed [7:0] NOISE_FLOOR_RST = -8'sd90;
  localparam logic [7:0]        TOP_CHANNEL_RST = 8'd11;

  localparam logic [3:0] LEN_SHORT = 4'd4;
  localparam logic [3:0] LEN_N40   = 4'd8;

  typedef enum logic [1:0] {
    MASK_G,
    MASK_B,
    MASK_N40
  } mask_id_t;

  typedef struct packed {
    logic signed [7:0] noise_floor;
    logic [7:0]        top_channel;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        chan;
    logic signed [7:0] dbm;
    mask_id_t          mask_id;
  } job_t;

  typedef struct packed {
    logic [7:0]        chan;
    logic signed [7:0] dbm;
    logic              last;
  } result_t;

  localparam logic signed [5:0] MASK_B_TAB [TAB_LEN] =
    '{6'sd0, 6'sd0, -6'sd30, -6'sd30, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
  localparam logic signed [5:0] MASK_G_TAB [TAB_LEN] =
    '{6'sd0, -6'sd10, -6'sd26, -6'sd28, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
  localparam logic signed [5:0] MASK_N40_TAB [TAB_LEN] =
    '{6'sd0, 6'sd0, 6'sd0, -6'sd10, -6'sd22, -6'sd25, -6'sd27, -6'sd30};

  function automatic logic signed [5:0] mask_db(mask_id_t id, logic [TAB_IDX_W-1:0] idx);
    logic signed [5:0] val;
    unique case (id)
      MASK_B:   val = MASK_B_TAB[idx];
      MASK_N40: val = MASK_N40_TAB[idx];
      default:  val = MASK_G_TAB[idx];
    endcase
    return val;
  endfunction

endpackage

/* hw/rtl/cis_front.sv */
// ----------------------------------------------------------------------------
// cis_front
// Accepts station reports, selects the spectral mask and works out which
// result slots are emitted, then queues the job for the back end.
// ----------------------------------------------------------------------------
module cis_front #(
  parameter int TAPS  = 8,
  parameter int SLOTS = 17
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cis_pkg::cfg_t            cfg,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [7:0]               in_primary_channel,
  input  logic signed [7:0]        in_strength,
  input  logic                     in_mode_b,
  input  logic                     in_mode_n,
  input  logic                     in_wide_40,
  output logic                     job_valid,
  input  logic                     job_pop,
  output cis_pkg::job_t            job,
  output logic [SLOTS-1:0]         job_slots
);
  import cis_pkg::*;

  job_t             new_job;
  logic [SLOTS-1:0] new_slots;
  logic             low;
  logic [3:0]       len;
  logic             push_ok;

  job_t             job_mem_r   [2];
  logic [SLOTS-1:0] slots_mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign low = in_primary_channel <= cfg.top_channel;

  always_comb begin
    new_job.chan = in_primary_channel;
    new_job.dbm  = in_strength;
    if (in_mode_b) begin
      new_job.mask_id = MASK_B;
    end else if (in_mode_n && in_wide_40) begin
      new_job.mask_id = MASK_N40;
    end else begin
      new_job.mask_id = MASK_G;
    end
    len = (new_job.mask_id == MASK_N40) ? LEN_N40 : LEN_SHORT;
  end

  always_comb begin
    logic signed [8:0] contrib;
    logic              tap_on;
    new_slots    = '0;
    new_slots[0] = 1'b1;
    for (int i = 0; i < TAPS; i++) begin
      contrib = 9'(in_strength) + 9'(mask_db(new_job.mask_id, TAB_IDX_W'(i)));
      tap_on  = low && (4'(i) < len) && (contrib >= 9'(cfg.noise_floor));
      new_slots[2*i+1] = tap_on &&
                         (({1'b0, in_primary_channel} + 9'(i + 1)) <= {1'b0, cfg.top_channel});
      new_slots[2*i+2] = tap_on && ({1'b0, in_primary_channel} > 9'(i + 1));
    end
  end

  assign in_full   = count_r == 2'd2;
  assign push_ok   = in_push && !in_full;
  assign job_valid = count_r != 2'd0;
  assign job       = job_mem_r[rd_ptr_r];
  assign job_slots = slots_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (job_pop && job_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push_ok) - 2'(job_pop && job_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      job_mem_r[wr_ptr_r]   <= new_job;
      slots_mem_r[wr_ptr_r] <= new_slots;
    end
  end

endmodule

/* hw/rtl/cis_back.sv */
// ----------------------------------------------------------------------------
// cis_back
// Walks the emitted slots of one job, one result beat per cycle while the output
// queue has room, and holds the results in a two-entry output queue.
// ----------------------------------------------------------------------------
module cis_back #(
  parameter int TAPS  = 8,
  parameter int SLOTS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_pop,
  input  cis_pkg::job_t        job,
  input  logic [SLOTS-1:0]     job_slots,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_channel,
  output logic signed [7:0]    out_strength,
  output logic                 out_last
);
  import cis_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int KW = $clog2(TAPS + 1);

  job_t             cur_r;
  logic [SLOTS-1:0] slots_r;
  logic             busy_r;

  logic [SLOTS-1:0] low_bit;
  logic [SLOTS-1:0] rest;
  logic [SW-1:0]    sel;
  logic [SW:0]      sel_inc;
  logic [KW-1:0]    k;
  logic             emit;
  logic             finish;
  result_t          res;

  result_t          obuf_r [2];
  logic             owr_ptr_r;
  logic             ord_ptr_r;
  logic [1:0]       ocount_r;
  logic             obuf_full;
  logic             opop_ok;

  assign low_bit = slots_r & (~slots_r + 1'b1);
  assign rest    = slots_r & ~low_bit;

  always_comb begin
    sel = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slots_r[s]) begin
        sel = SW'(s);
      end
    end
  end

  assign sel_inc = {1'b0, sel} + 1'b1;
  assign k       = KW'(sel_inc >> 1);

  always_comb begin
    logic signed [8:0] contrib;
    contrib  = 9'(cur_r.dbm) + 9'(mask_db(cur_r.mask_id, TAB_IDX_W'(k - 1'b1)));
    res.last = rest == '0;
    if (sel == '0) begin
      res.chan = cur_r.chan;
      res.dbm  = cur_r.dbm;
    end else begin
      res.dbm  = contrib[7:0];
      res.chan = sel[0] ? (cur_r.chan + 8'(k)) : (cur_r.chan - 8'(k));
    end
  end

  assign obuf_full = ocount_r == 2'd2;
  assign emit      = busy_r && !obuf_full;
  assign finish    = emit && res.last;
  assign job_pop   = job_valid && (!busy_r || finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (job_pop) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r   <= job;
      slots_r <= job_slots;
    end else if (emit) begin
      slots_r <= rest;
    end
  end

  assign out_empty    = ocount_r == 2'd0;
  assign opop_ok      = out_pop && !out_empty;
  assign out_channel  = obuf_r[ord_ptr_r].chan;
  assign out_strength = obuf_r[ord_ptr_r].dbm;
  assign out_last     = obuf_r[ord_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= 1'b0;
      ord_ptr_r <= 1'b0;
      ocount_r  <= 2'd0;
    end else begin
      if (emit) begin
        owr_ptr_r <= !owr_ptr_r;
      end
      if (opop_ok) begin
        ord_ptr_r <= !ord_ptr_r;
      end
      ocount_r <= ocount_r + 2'(emit) - 2'(opop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf_r[owr_ptr_r] <= res;
    end
  end

endmodule

/* hw/rtl/channel_interference_spreader.sv */
// ----------------------------------------------------------------------------
// channel_interference_spreader
// Spreads one access point report over the neighboring channels that its
// signal reaches, using a spectral mask chosen from the mode flags.
// ----------------------------------------------------------------------------
// A report's first result beat passes the input queue, walker and output queue registers.
// Throughput: one result beat per cycle while the output queue has room; a report
// yields 1 to 2*min(MASK_TAPS,8)+1 result beats (17 at the default) from the slot walker.
// Reports queue two deep ahead of the walker, results two deep behind it.
// Reset is synchronous and active low; it empties both queues and reloads the
// noise floor (-90) and the top low-band channel (11).
module channel_interference_spreader #(
  parameter int MASK_TAPS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_primary_channel,
  input  logic signed [7:0]             in_strength,
  input  logic                          in_mode_b,
  input  logic                          in_mode_n,
  input  logic                          in_wide_40,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_channel,
  output logic signed [7:0]             out_strength,
  output logic                          out_last
);
  import cis_pkg::*;

  localparam int TAPS  = (MASK_TAPS < TAB_LEN) ? MASK_TAPS : TAB_LEN;
  localparam int SLOTS = 2 * TAPS + 1;

  cfg_t             cfg_r;
  logic             job_valid;
  logic             job_pop;
  job_t             job;
  logic [SLOTS-1:0] job_slots;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.noise_floor <= NOISE_FLOOR_RST;
      cfg_r.top_channel <= TOP_CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOISE_FLOOR: cfg_r.noise_floor <= cfg_data;
        CFG_TOP_CHANNEL: cfg_r.top_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  cis_front #(
    .TAPS  (TAPS),
    .SLOTS (SLOTS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_primary_channel (in_primary_channel),
    .in_strength        (in_strength),
    .in_mode_b          (in_mode_b),
    .in_mode_n          (in_mode_n),
    .in_wide_40         (in_wide_40),
    .job_valid          (job_valid),
    .job_pop            (job_pop),
    .job                (job),
    .job_slots          (job_slots)
  );

  cis_back #(
    .TAPS  (TAPS),
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_pop      (job_pop),
    .job          (job),
    .job_slots    (job_slots),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_channel  (out_channel),
    .out_strength (out_strength),
    .out_last     (out_last)
  );

endmodule

/* hw/rtl/cis_checker.sv */
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks of the interference spreader, bound to its top level.
// ----------------------------------------------------------------------------
module cis_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [7:0]                    out_channel,
  input  logic signed [7:0]             out_strength,
  input  logic                          out_last
);

  logic [3:0] open_r;
  logic       in_beat;
  logic       last_beat;

  assign in_beat   = in_push && !in_full;
  assign last_beat = out_pop && !out_empty && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 4'd0;
    end else begin
      open_r <= open_r + 4'(in_beat) - 4'(last_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_channel) &&
                               $stable(out_strength) && $stable(out_last))
    else $error("waiting result beat changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> open_r != 4'd0)
    else $error("result beat without an open report");

  a_full_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> open_r >= 4'd2)
    else $error("input full with fewer than two open reports");

endmodule

bind channel_interference_spreader cis_checker u_cis_checker (.*);
